[rtl/core/pgau_pkg.sv]
// ----------------------------------------------------------------------------
// pgau_pkg: shared types and constants of the packed glyph alpha unpacker
// Pixel depth codes, register indexes, the queue entry and the config bundle.
// ----------------------------------------------------------------------------
package pgau_pkg;

	// pixel depth codes
	localparam logic [1:0] DEPTH_1BPP = 2'd0;
	localparam logic [1:0] DEPTH_2BPP = 2'd1;
	localparam logic [1:0] DEPTH_4BPP = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PIXEL_DEPTH  = 2'd0;
	localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd1;
	localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd2;

	localparam int CFG_DATA_W = 8;

	// front-to-back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// 2 bpp code to alpha
	localparam logic [7:0] TWO_BIT_ALPHA [4] = '{8'd0, 8'd85, 8'd170, 8'd255};

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       glyph_start;
	} queue_item_t;

	typedef struct packed {
		logic [1:0] pixel_depth;
		logic [7:0] glyph_width;
		logic [7:0] glyph_height;
	} glyph_cfg_t;

	typedef struct packed {
		logic        valid;
		queue_item_t item;
	} queue_head_t;

endpackage

[rtl/core/pgau_front.sv]
// ----------------------------------------------------------------------------
// pgau_front: input stage of the glyph unpacker
// Takes byte beats into a short queue that decouples them from the pixel engine.
// ----------------------------------------------------------------------------
module pgau_front
	import pgau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  packed_byte,
	input  logic        glyph_start,
	output queue_head_t head,
	input  logic        pop
);

	queue_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop_ok;

	assign in_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign pop_ok   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{packed_byte: packed_byte, glyph_start: glyph_start};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

endmodule

[rtl/core/pgau_back.sv]
// ----------------------------------------------------------------------------
// pgau_back: pixel engine of the glyph unpacker
// Expands the byte, one pixel per unstalled cycle; tracks row, column and phase.
// ----------------------------------------------------------------------------
module pgau_back
	import pgau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  glyph_cfg_t  cfg,
	input  queue_head_t head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  alpha,
	output logic [7:0]  pixel_column,
	output logic [7:0]  pixel_row,
	output logic        row_end,
	output logic        glyph_end,
	output logic        last
);

	logic [7:0] byte_q;
	logic       busy_q;
	logic [7:0] col_q;
	logic [7:0] row_q;
	logic [1:0] phase_q;
	logic       done_q;
	logic       out_valid_q;

	logic       slot_free;
	logic       emit;
	logic       re;
	logic       ge;
	logic       over;
	logic       stop;
	logic [7:0] pix_alpha;
	logic [7:0] col_a;
	logic [7:0] row_a;
	logic [1:0] phase_a;
	logic [1:0] phase_inc;
	logic [3:0] nib;
	logic [7:0] col_n;
	logic [7:0] row_n;
	logic [1:0] phase_n;
	logic       done_n;
	logic       skip;
	logic       bad_depth;

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = busy_q && slot_free;

	assign re = ({1'b0, col_q} + 9'd1) == {1'b0, cfg.glyph_width};
	assign ge = re && (({1'b0, row_q} + 9'd1) == {1'b0, cfg.glyph_height});

	assign phase_inc = phase_q + 2'd1;
	assign nib       = phase_q[0] ? byte_q[3:0] : byte_q[7:4];

	// one pixel from the current state
	always_comb begin
		pix_alpha = '0;
		phase_a   = '0;
		over      = 1'b0;
		col_a     = re ? 8'd0 : col_q + 8'd1;
		row_a     = re ? row_q + 8'd1 : row_q;
		case (cfg.pixel_depth)
			DEPTH_1BPP: begin
				pix_alpha = byte_q[3'd7 - col_q[2:0]] ? 8'hff : 8'h00;
				phase_a   = '0;
				over      = (col_a[2:0] == 3'd0);
			end
			DEPTH_2BPP: begin
				case (phase_q)
					2'd0:    pix_alpha = TWO_BIT_ALPHA[byte_q[7:6]];
					2'd1:    pix_alpha = TWO_BIT_ALPHA[byte_q[5:4]];
					2'd2:    pix_alpha = TWO_BIT_ALPHA[byte_q[3:2]];
					default: pix_alpha = TWO_BIT_ALPHA[byte_q[1:0]];
				endcase
				phase_a = phase_inc;
				over    = (phase_inc == 2'd0);
			end
			DEPTH_4BPP: begin
				pix_alpha = {nib, nib};
				phase_a   = {1'b0, phase_inc[0]};
				over      = !phase_inc[0];
			end
			default: begin
				pix_alpha = '0;
			end
		endcase
	end

	assign stop = ge || over;

	// state after this cycle's pixel
	assign col_n   = emit ? (ge ? 8'd0 : col_a) : col_q;
	assign row_n   = emit ? (ge ? 8'd0 : row_a) : row_q;
	assign phase_n = emit ? (ge ? 2'd0 : phase_a) : phase_q;
	assign done_n  = done_q || (emit && ge);

	assign pop = head.valid && (!busy_q || (emit && stop));

	assign bad_depth = (cfg.pixel_depth != DEPTH_1BPP) && (cfg.pixel_depth != DEPTH_2BPP)
		&& (cfg.pixel_depth != DEPTH_4BPP);
	assign skip = (done_n && !head.item.glyph_start) || bad_depth
		|| (cfg.glyph_width == 8'd0) || (cfg.glyph_height == 8'd0);

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q <= head.item.packed_byte;
		end
		if (emit) begin
			alpha        <= pix_alpha;
			pixel_column <= col_q;
			pixel_row    <= row_q;
			row_end      <= re;
			glyph_end    <= ge;
			last         <= stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			phase_q     <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.item.glyph_start) begin
				col_q   <= '0;
				row_q   <= '0;
				phase_q <= '0;
				done_q  <= 1'b0;
			end else begin
				col_q   <= col_n;
				row_q   <= row_n;
				phase_q <= phase_n;
				done_q  <= done_n;
			end
			if (pop) begin
				busy_q <= !skip;
			end else if (emit && stop) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (col_q == 8'd0) && (row_q == 8'd0) && (phase_q == 2'd0))
		else $error("finished glyph left counters nonzero");

	a_busy_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q)
		else $error("engine busy on a finished glyph");

	a_glyph_end_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit && ge && !(pop && head.item.glyph_start) |=> done_q && !busy_q)
		else $error("last pixel of glyph did not close it");

endmodule

[rtl/core/packed_glyph_alpha_unpacker_top.sv]
// ----------------------------------------------------------------------------
// packed_glyph_alpha_unpacker_top: packed 1/2/4 bpp glyph bitmap to 8-bit alpha
// Top level: configuration registers, input queue and pixel engine.
// ----------------------------------------------------------------------------
// Each byte beat on the input expands into up to eight alpha pixel beats in
// raster order, one pixel per clock while the output is taken: eight pixels
// at 1 bpp mid-row, four at 2 bpp, two at 4 bpp. A byte that yields nothing
// (glyph already finished, zero width or height, unused depth code) is
// dropped without a pixel. The single-pixel emitter is what sets the rate. A
// two-entry queue in front of the engine keeps taking bytes while the engine
// works, and a registered output stage holds each pixel until it is taken;
// the engine stalls while that pixel waits. At 1 bpp every row starts on a
// fresh byte; at 2 and 4 bpp pixels pack straight across rows. glyph_start
// on a byte restarts row, column and packing position before that byte is
// used. Write the configuration registers (0 depth, 1 width, 2 height) only
// while the block is idle; writes to other indexes are ignored.
// ----------------------------------------------------------------------------
module packed_glyph_alpha_unpacker_top
	import pgau_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// byte input
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            packed_byte,
	input  logic                  glyph_start,
	// pixel output
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            alpha,
	output logic [7:0]            pixel_column,
	output logic [7:0]            pixel_row,
	output logic                  row_end,
	output logic                  glyph_end,
	output logic                  last
);

	glyph_cfg_t  cfg_q;
	queue_head_t head;
	logic        pop;

	// Hold the configuration; only the low bits of the write data matter for
	// the depth code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PIXEL_DEPTH:  cfg_q.pixel_depth  <= cfg_data[1:0];
				REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= cfg_data[7:0];
				REG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data[7:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// Front: take byte beats into the queue.
	pgau_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.packed_byte (packed_byte),
		.glyph_start (glyph_start),
		.head        (head),
		.pop         (pop)
	);

	// Back: expand the byte at the head of the queue into pixel beats.
	pgau_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.alpha        (alpha),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.row_end      (row_end),
		.glyph_end    (glyph_end),
		.last         (last)
	);

endmodule
